### sv/togd_pkg.sv
// shared constants, types and reset values for the timed output group driver
package togd_pkg;

   localparam int CHANNELS_DEFAULT = 5;
   localparam int MAX_CHANNELS     = 5;
   localparam int NUM_MODE_REGS    = 5;

   localparam int FUNC_W    = 3;
   localparam int CHANNEL_W = 3;
   localparam int LEVEL_W   = 16;
   localparam int MODE_W    = 8;
   localparam int PINS_W    = 5;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_TICK      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET       = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_GROUP_ON  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_GROUP_OFF = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_COND      = 3'd4;

   localparam logic [MODE_W-1:0] MODE_RESET [NUM_MODE_REGS] =
      '{8'd0, 8'd1, 8'd2, 8'd3, 8'd3};

   // request as seen by one channel cell
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic               hit;      // request targets this channel
      logic               mode_eq;  // channel mode equals mode_match
      logic [LEVEL_W-1:0] level;
   } togd_cmd_type;

endpackage

### sv/timed_output_group_driver.sv
// top level of the timed output group driver
// a request is registered on acceptance; its pin vector enters the result register once that
//    register can take it (empty or rsp_stall low), which raises rsp_valid
// throughput: one request per cycle while rsp_stall is low; the per-channel update is one compare and decrement
// reset: synchronous, pins low, countdowns zero, modes back to their defaults
module timed_output_group_driver #(
   parameter int CHANNELS = togd_pkg::CHANNELS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [togd_pkg::FUNC_W-1:0]      req_func,
   input  logic [togd_pkg::CHANNEL_W-1:0]   req_channel,
   input  logic [togd_pkg::LEVEL_W-1:0]     req_level_value,
   input  logic [togd_pkg::MODE_W-1:0]      req_mode_match,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [togd_pkg::PINS_W-1:0]      rsp_pin_vector,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [togd_pkg::ADDR_W-1:0]      csr_paddr,
   input  logic [togd_pkg::DATA_W-1:0]      csr_pwdata,
   output logic [togd_pkg::DATA_W-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import togd_pkg::*;

   // mode registers, one per channel slot, always all five present
   logic [MODE_W-1:0]    mode_ff [NUM_MODE_REGS];
   logic [REG_IDX_W-1:0] csr_idx;
   logic                 csr_wr;

   // input register
   logic                 in_valid_ff;
   logic [FUNC_W-1:0]    func_ff;
   logic [CHANNEL_W-1:0] channel_ff;
   logic [LEVEL_W-1:0]   level_ff;
   logic [MODE_W-1:0]    match_ff;

   // result register
   logic                 out_valid_ff;
   logic [PINS_W-1:0]    pins_out_ff;

   logic                 advance;
   logic                 req_take;

   // register access, word addressed
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_MODE_REGS; i++) mode_ff[i] <= MODE_RESET[i];
      end else if (csr_wr && (csr_idx < REG_IDX_W'(NUM_MODE_REGS))) begin
         mode_ff[csr_idx] <= csr_pwdata[MODE_W-1:0];
      end
   end

   // unmapped addresses read as zero
   always_comb begin
      csr_prdata = '0;
      if (csr_idx < REG_IDX_W'(NUM_MODE_REGS)) csr_prdata = DATA_W'(mode_ff[csr_idx]);
   end

   // the input register empties whenever the result register can take its outcome
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // payload holds no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff    <= req_func;
         channel_ff <= req_channel;
         level_ff   <= req_level_value;
         match_ff   <= req_mode_match;
      end
   end

   // channel cells; out-of-range channel numbers hit no cell
   logic [PINS_W-1:0] cell_next;

   for (genvar g = 0; g < PINS_W; g++) begin : g_chan
      if (g < CHANNELS) begin : g_used
         togd_cmd_type cmd;
         assign cmd.func    = func_ff;
         assign cmd.hit     = (channel_ff == CHANNEL_W'(g));
         assign cmd.mode_eq = (mode_ff[g] == match_ff);
         assign cmd.level   = level_ff;

         togd_chan u_chan (
            .clock    (clock),
            .reset    (reset),
            .enable   (advance),
            .cmd      (cmd),
            .pin_next (cell_next[g])
         );
      end else begin : g_unused
         // absent channels stay low
         assign cell_next[g] = 1'b0;
      end
   end

   // result register, doubles as the skid between the two sides
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) pins_out_ff <= cell_next;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pin_vector = pins_out_ff;

endmodule

### sv/togd_chan.sv
// one output channel: pin level and auto-off countdown
module togd_chan (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  togd_pkg::togd_cmd_type cmd,
   output logic                  pin_next
);
   import togd_pkg::*;

   logic               pin_ff, pin_in;
   logic [LEVEL_W-1:0] count_ff, count_in;

   always_comb begin
      pin_in   = pin_ff;
      count_in = count_ff;
      unique case (cmd.func)
         FUNC_TICK: begin
            if (count_ff != '0) begin
               count_in = count_ff - LEVEL_W'(1);
               if (count_ff == LEVEL_W'(1)) pin_in = 1'b0;
            end
         end
         FUNC_SET: begin
            if (cmd.hit) begin
               pin_in = (cmd.level != '0);
               if (cmd.level > LEVEL_W'(1)) count_in = cmd.level;
            end
         end
         FUNC_GROUP_ON: begin
            if (cmd.mode_eq) pin_in = 1'b1;
         end
         FUNC_GROUP_OFF: begin
            if (cmd.mode_eq) pin_in = 1'b0;
         end
         FUNC_COND: begin
            if (cmd.hit && cmd.mode_eq) pin_in = (cmd.level != '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_ff   <= 1'b0;
         count_ff <= '0;
      end else if (enable) begin
         pin_ff   <= pin_in;
         count_ff <= count_in;
      end
   end

   assign pin_next = pin_in;

endmodule
